### sv/assert_macros.svh
// Assertion helpers used by the property checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define BSFF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define BSFF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/bsff_pkg.sv
`timescale 1ns / 1ps
package bsff_pkg;

   localparam int BASE_W  = 32;
   localparam int SIZE_W  = 11;
   localparam int POS_W   = SIZE_W + 1;
   localparam int MAX_POS = 2047;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_IN_USE = 2'd1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_ADD    = 3'd1,
      OP_REMOVE = 3'd2,
      OP_TEST   = 3'd3,
      OP_MIN    = 3'd4,
      OP_MAX    = 3'd5,
      OP_START  = 3'd6,
      OP_NEXT   = 3'd7
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [BASE_W-1:0]   index;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [BASE_W-1:0]   entry_index;
      logic                status;
      logic                walk_active;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_ACCESS,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic clear_all;
      logic cursor_zero;
      logic loc_step;
      logic rd_issue;
      logic modify;
      logic set_status;
      logic scan;
      logic take_hit;
      logic cursor_hit;
      logic walk_end;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_range;
      logic loc_hit;
      logic issue_end;
      logic eval_valid;
      logic eval_hit;
      logic out_free;
   } stat_type;

endpackage

### sv/bsff_ctrl.sv
`timescale 1ns / 1ps
module bsff_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  bsff_pkg::op_type   req_op,
   output logic               req_ready,
   input  bsff_pkg::stat_type stat,
   output bsff_pkg::cmd_type  cmd
);
   import bsff_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      is_walk;
   logic      is_max;

   assign is_walk = (op_ff == OP_START) || (op_ff == OP_NEXT);
   assign is_max  = (op_ff == OP_MAX);

   // state and opcode registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_CLEAR;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               op_in     = req_op;
               if (req_op == OP_CLEAR) begin
                  cmd.clear_all = 1'b1;
                  state_in      = ST_FINISH;
               end else if (req_op inside {OP_ADD, OP_REMOVE, OP_TEST}) begin
                  state_in = ST_LOCATE;
               end else begin
                  cmd.cursor_zero = (req_op == OP_START);
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_LOCATE: begin
            if (stat.out_range) begin
               cmd.set_status = 1'b1;
               state_in       = ST_FINISH;
            end else if (stat.loc_hit) begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_ACCESS;
            end else begin
               cmd.loc_step = 1'b1;
            end
         end
         ST_ACCESS: begin
            cmd.modify = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.eval_valid && stat.eval_hit) begin
               cmd.take_hit   = 1'b1;
               cmd.cursor_hit = is_walk;
               if (!is_max) begin
                  state_in = ST_FINISH;
               end
            end else if (stat.issue_end && !stat.eval_valid) begin
               cmd.walk_end = is_walk;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### sv/bsff_dpath.sv
`timescale 1ns / 1ps
module bsff_dpath #(
   parameter int CAPACITY  = 1024,
   parameter int WORD_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bsff_pkg::req_type                   req_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bsff_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bsff_pkg::BASE_W-1:0]         csr_wdata,
   input  bsff_pkg::cmd_type                   cmd,
   output bsff_pkg::stat_type                  stat,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output bsff_pkg::rsp_type                   rsp_payload
);
   import bsff_pkg::*;

   // positions past the size register limit are never reached
   localparam int CAP_LIM = (CAPACITY < MAX_POS) ? CAPACITY : MAX_POS;
   localparam int DEPTH   = (CAP_LIM + WORD_BITS - 1) / WORD_BITS;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW      = $clog2(WORD_BITS);

   logic [BASE_W-1:0]    base_ff;
   logic [SIZE_W-1:0]    size_ff;
   op_type               op_ff;
   logic [BASE_W-1:0]    index_ff;
   logic [AW-1:0]        w_ff;
   logic [POS_W-1:0]     wpos_ff;
   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [DEPTH-1:0]     valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic                 eval_ff;
   logic [POS_W-1:0]     epos_ff;
   logic [POS_W-1:0]     cursor_ff;
   logic                 res_found_ff;
   logic [POS_W-1:0]     res_hit_ff;
   logic                 res_status_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff;

   logic [POS_W-1:0]     eff;
   logic [BASE_W:0]      rel;
   logic [POS_W-1:0]     rel_pos;
   logic [OW-1:0]        bit_off;
   logic [WORD_BITS-1:0] bit_mask;
   logic [WORD_BITS-1:0] word_q;
   logic [WORD_BITS-1:0] wr_word;
   logic                 wr_en;
   logic                 issue_end;
   logic                 rd_en;
   logic                 advance;
   logic [POS_W-1:0]     lo_lim;
   logic [WORD_BITS-1:0] masked;
   logic [OW-1:0]        lo_bit;
   logic [OW-1:0]        hi_bit;
   logic [POS_W-1:0]     hit_pos;
   logic                 is_search;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         size_ff <= SIZE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BASE_OFFSET: base_ff <= csr_wdata;
            CSR_SIZE_IN_USE: size_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp size to capacity
   assign eff = ({1'b0, size_ff} > POS_W'(CAP_LIM)) ? POS_W'(CAP_LIM) : {1'b0, size_ff};

   // range check and bit location for add, remove, test
   assign rel       = {1'b0, index_ff} - {1'b0, base_ff};
   assign rel_pos   = rel[POS_W-1:0];
   assign bit_off   = OW'(rel_pos - wpos_ff);
   assign bit_mask  = WORD_BITS'(1) << bit_off;
   assign issue_end = (wpos_ff >= eff);

   assign stat.out_range  = rel[BASE_W] || (rel[BASE_W-1:0] >= BASE_W'(eff));
   assign stat.loc_hit    = (rel_pos < wpos_ff + POS_W'(WORD_BITS));
   assign stat.issue_end  = issue_end;
   assign stat.eval_valid = eval_ff;
   assign stat.eval_hit   = eval_ff && (|masked);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   // capture request
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff    <= req_payload.op;
         index_ff <= req_payload.index;
      end
   end

   // word counter for locate and scan
   assign advance = cmd.loc_step || (cmd.scan && !issue_end);
   assign rd_en   = cmd.rd_issue || (cmd.scan && !issue_end);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         w_ff    <= '0;
         wpos_ff <= '0;
      end else if (advance) begin
         w_ff    <= w_ff + AW'(1);
         wpos_ff <= wpos_ff + POS_W'(WORD_BITS);
      end
   end

   // bitmap memory, registered read
   assign word_q  = rd_valid_ff ? rd_data_ff : '0;
   assign wr_en   = cmd.modify && (op_ff != OP_TEST);
   assign wr_word = (op_ff == OP_ADD) ? (word_q | bit_mask) : (word_q & ~bit_mask);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[w_ff];
         rd_valid_ff <= valid_ff[w_ff];
      end
      if (wr_en) begin
         mem[w_ff] <= wr_word;
      end
   end

   // word valid flags; an unwritten word reads as zero
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[w_ff] <= 1'b1;
      end
   end

   // evaluate stage tracks the word just read
   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         eval_ff <= 1'b0;
      end else begin
         eval_ff <= cmd.scan && !issue_end;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && !issue_end) begin
         epos_ff <= wpos_ff;
      end
   end

   // mask the word to [lo_lim, eff) and priority-encode both ends
   assign lo_lim = ((op_ff == OP_START) || (op_ff == OP_NEXT)) ? cursor_ff : '0;

   always_comb begin
      logic [POS_W:0]       dhi;
      logic [POS_W:0]       dlo;
      logic [WORD_BITS-1:0] ones;
      logic [WORD_BITS-1:0] mhi;
      logic [WORD_BITS-1:0] mlo;
      ones = '1;
      dhi  = {1'b0, eff} - {1'b0, epos_ff};
      dlo  = {1'b0, lo_lim} - {1'b0, epos_ff};
      if (dhi[POS_W] || (dhi == '0)) begin
         mhi = '0;
      end else if (dhi >= (POS_W + 1)'(WORD_BITS)) begin
         mhi = ones;
      end else begin
         mhi = ~(ones << dhi[OW-1:0]);
      end
      if (dlo[POS_W] || (dlo == '0)) begin
         mlo = ones;
      end else if (dlo >= (POS_W + 1)'(WORD_BITS)) begin
         mlo = '0;
      end else begin
         mlo = ones << dlo[OW-1:0];
      end
      masked = word_q & mhi & mlo;
   end

   always_comb begin
      lo_bit = '0;
      hi_bit = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (masked[j]) lo_bit = OW'(j);
      end
      for (int j = 0; j < WORD_BITS; j++) begin
         if (masked[j]) hi_bit = OW'(j);
      end
   end

   assign hit_pos = epos_ff + {{(POS_W - OW){1'b0}}, (op_ff == OP_MAX) ? hi_bit : lo_bit};

   // walk cursor
   always_ff @(posedge clock) begin
      if (reset || cmd.cursor_zero) begin
         cursor_ff <= '0;
      end else if (cmd.cursor_hit) begin
         cursor_ff <= hit_pos + POS_W'(1);
      end else if (cmd.walk_end) begin
         cursor_ff <= eff + POS_W'(1);
      end
   end

   // result fields of the item in work
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         res_found_ff  <= 1'b0;
         res_hit_ff    <= '0;
         res_status_ff <= 1'b0;
      end else begin
         if (cmd.set_status) res_status_ff <= 1'b1;
         if (cmd.modify && (op_ff == OP_TEST)) res_found_ff <= |(word_q & bit_mask);
         if (cmd.take_hit) begin
            res_found_ff <= 1'b1;
            res_hit_ff   <= hit_pos;
         end
      end
   end

   // output register
   assign is_search = (op_ff inside {OP_MIN, OP_MAX, OP_START, OP_NEXT});

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff.found       <= res_found_ff;
         rsp_data_ff.entry_index <= (res_found_ff && is_search) ?
                                    base_ff + BASE_W'(res_hit_ff) : '0;
         rsp_data_ff.status      <= res_status_ff;
         rsp_data_ff.walk_active <= (cursor_ff != '0) && (cursor_ff <= eff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

### sv/bitmap_set_find_first.sv
// Clear goes straight to the result; add, remove and test step to the target
//   word and read it, add and remove write it back (out of range: straight to
//   the result); min and hitting walks scan up to the hit, max and misses to size_in_use.
// One request at a time, next transfer the cycle after the load.
// Reset: bitmap empty at once through per-word valid flags, walk cursor
//   zero, base_offset 0, size_in_use 1024.
`timescale 1ns / 1ps
module bitmap_set_find_first #(
   parameter int CAPACITY  = 1024,
   parameter int WORD_BITS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bsff_pkg::req_type              req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bsff_pkg::rsp_type              rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bsff_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsff_pkg::BASE_W-1:0]    csr_wdata
);
   import bsff_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   bsff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.op),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // bitmap, scan and result datapath
   bsff_dpath #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

### sv/bsff_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bsff_props (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bsff_pkg::rsp_type rsp_payload
);

   // a stalled result holds
   `BSFF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result changed")

   // one request at a time: busy right after a transfer
   `BSFF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   // nothing found means no entry index
   `BSFF_ASSERT_NOW(a_entry_zero, clock, reset, rsp_valid && !rsp_payload.found, rsp_payload.entry_index == '0, "entry index without a hit")

   // an out-of-range request never reports a hit
   `BSFF_ASSERT_NOW(a_status_no_hit, clock, reset, rsp_valid && rsp_payload.status, !rsp_payload.found, "hit reported with error status")

endmodule

bind bitmap_set_find_first bsff_props u_bsff_props (.*);

### bench/bsff_checker.sv
`timescale 1ns / 1ps
module bsff_checker #(
   parameter int CAPACITY = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  bsff_pkg::req_type              req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  bsff_pkg::rsp_type              rsp_payload,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [bsff_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsff_pkg::BASE_W-1:0]    csr_wdata,
   output int                             mismatches,
   output int                             outstanding
);
   import bsff_pkg::*;

   // shadow copy of the set, the walk position and the two registers
   logic [CAPACITY-1:0] member_bits;
   int unsigned         walk_pos;
   logic [BASE_W-1:0]   base_offset;
   logic [SIZE_W-1:0]   size_in_use;
   rsp_type             expected_rsp[$];

   task automatic flag_mismatch(input string what, input logic [BASE_W-1:0] got,
                                input logic [BASE_W-1:0] want);
      $display("%0t ns mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatches++;
   endtask

   // positions in use, capped at the bitmap capacity
   function automatic int unsigned span();
      return (size_in_use > CAPACITY) ? CAPACITY : int'(size_in_use);
   endfunction

   // ascending walk from the cursor; park the cursor one past the end on a miss
   function automatic logic walk_step(output int unsigned hit);
      int unsigned lim;
      lim = span();
      hit = 0;
      for (int unsigned i = walk_pos; i < lim; i++) begin
         if (member_bits[i]) begin
            walk_pos = i + 1;
            hit = i;
            return 1'b1;
         end
      end
      walk_pos = lim + 1;
      return 1'b0;
   endfunction

   // apply one request to the shadow set and return the result it should give
   function automatic rsp_type predict_response(input req_type item);
      rsp_type     res;
      int unsigned lim;
      int unsigned hit;
      int unsigned pos;
      logic        hit_ok;
      logic        in_range;
      lim = span();
      res = '0;
      hit = 0;
      hit_ok = 1'b0;
      in_range = (item.index >= base_offset) && ((item.index - base_offset) < lim);
      pos = item.index - base_offset;
      case (item.op)
         OP_CLEAR: member_bits = '0;
         OP_ADD, OP_REMOVE, OP_TEST: begin
            if (!in_range) begin
               res.status = 1'b1;
            end else if (item.op == OP_ADD) begin
               member_bits[pos] = 1'b1;
            end else if (item.op == OP_REMOVE) begin
               member_bits[pos] = 1'b0;
            end else begin
               res.found = member_bits[pos];
            end
         end
         OP_MIN: begin
            for (int unsigned i = 0; i < lim; i++) begin
               if (member_bits[i]) begin
                  hit_ok = 1'b1;
                  hit = i;
                  break;
               end
            end
         end
         OP_MAX: begin
            for (int i = int'(lim) - 1; i >= 0; i--) begin
               if (member_bits[i]) begin
                  hit_ok = 1'b1;
                  hit = i;
                  break;
               end
            end
         end
         OP_START: begin
            walk_pos = 0;
            hit_ok = walk_step(hit);
         end
         OP_NEXT: hit_ok = walk_step(hit);
         default: ;
      endcase
      // the absolute index wraps at 32 bits
      if (hit_ok) begin
         res.found = 1'b1;
         res.entry_index = base_offset + hit;
      end
      res.walk_active = (walk_pos >= 1) && (walk_pos <= lim);
      return res;
   endfunction

   // compare results first, then take register writes and new requests
   always @(posedge clock) begin : track
      rsp_type want;
      if (reset) begin
         member_bits = '0;
         walk_pos = 0;
         base_offset = '0;
         size_in_use = SIZE_RESET;
         expected_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               flag_mismatch("unexpected result", rsp_payload.entry_index, '0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_payload.found !== want.found)
                  flag_mismatch("found", BASE_W'(rsp_payload.found), BASE_W'(want.found));
               if (rsp_payload.entry_index !== want.entry_index)
                  flag_mismatch("entry_index", rsp_payload.entry_index, want.entry_index);
               if (rsp_payload.status !== want.status)
                  flag_mismatch("status", BASE_W'(rsp_payload.status), BASE_W'(want.status));
               if (rsp_payload.walk_active !== want.walk_active)
                  flag_mismatch("walk_active", BASE_W'(rsp_payload.walk_active),
                                BASE_W'(want.walk_active));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_OFFSET: base_offset = csr_wdata;
               CSR_SIZE_IN_USE: size_in_use = csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_rsp.push_back(predict_response(req_payload));
      end
      outstanding <= expected_rsp.size();
   end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
   import bsff_pkg::*;

   localparam int LIMIT_NS = 3_000_000;
   localparam int SPAN_MAX = 1024;
   localparam int PHASES   = 11;
   localparam int PER_PHASE = 103;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BASE_OFFSET;
   logic [BASE_W-1:0]    csr_wdata = '0;

   int                   mismatches;
   int                   outstanding;
   bit                   quiet = 1'b0;
   int                   req_gap = 0;
   int                   sink_wait = 0;
   int                   items_sent = 0;
   logic [BASE_W-1:0]    cur_base = '0;
   logic [SIZE_W-1:0]    cur_size = SIZE_RESET;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   bitmap_set_find_first DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   bsff_checker bitmap_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // stall the result channel for a random count after each transfer
   always @(posedge clock) begin : rsp_sink
      int draw;
      draw = quiet ? 0 : $urandom_range(0, 19);
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_wait <= draw;
      end else if (!rsp_ready) begin
         if (sink_wait <= 1) rsp_ready <= 1'b1;
         else sink_wait <= sink_wait - 1;
      end else if (rsp_valid && draw != 0) begin
         rsp_ready <= 1'b0;
         sink_wait <= draw;
      end
   end

   // hold valid across back-to-back transfers; drop it only ahead of a gap
   task automatic send_request(input op_type code, input logic [BASE_W-1:0] where);
      repeat (req_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_payload <= '{op: code, index: where};
      do @(posedge clock); while (!req_ready);
      items_sent++;
      req_gap = quiet ? 0 : $urandom_range(0, 19);
      if (req_gap != 0) req_valid <= 1'b0;
   endtask

   task automatic await_results();
      if (req_gap == 0) req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // write both registers in two back-to-back transfers
   task automatic apply_settings(input logic [BASE_W-1:0] base, input logic [BASE_W-1:0] size);
      csr_valid <= 1'b1;
      csr_index <= CSR_BASE_OFFSET;
      csr_wdata <= base;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_SIZE_IN_USE;
      csr_wdata <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_base = base;
      cur_size = size[SIZE_W-1:0];
   endtask

   // mostly in-range updates and walks, with edges and raw noise mixed in
   task automatic random_item();
      int unsigned       lim;
      int unsigned       pick;
      int unsigned       steps;
      logic [2:0]        code;
      logic [BASE_W-1:0] spot;
      logic [BASE_W-1:0] rim;
      lim = (cur_size > SPAN_MAX) ? SPAN_MAX : int'(cur_size);
      spot = (lim == 0) ? cur_base : cur_base + $urandom_range(0, lim - 1);
      case ($urandom_range(0, 3))
         0: rim = cur_base - 1;
         1: rim = cur_base;
         2: rim = cur_base + lim - 1;
         default: rim = cur_base + lim;
      endcase
      code = 3'($urandom_range(int'(OP_ADD), int'(OP_TEST)));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         send_request(OP_ADD, spot);
      end else if (pick < 40) begin
         send_request(OP_REMOVE, spot);
      end else if (pick < 50) begin
         send_request(OP_TEST, spot);
      end else if (pick < 56) begin
         send_request(op_type'(code), rim);
      end else if (pick < 61) begin
         code = 3'($urandom_range(int'(OP_CLEAR), int'(OP_NEXT)));
         send_request(op_type'(code), $urandom);
      end else if (pick < 66) begin
         send_request(OP_MIN, spot);
      end else if (pick < 71) begin
         send_request(OP_MAX, spot);
      end else if (pick < 80) begin
         steps = $urandom_range(1, 10);
         send_request(OP_START, spot);
         repeat (steps) send_request(OP_NEXT, $urandom);
      end else if (pick < 82) begin
         send_request(OP_CLEAR, spot);
      end else begin
         send_request(OP_NEXT, spot);
      end
   endtask

   initial begin : stimulus
      logic [BASE_W-1:0] base_list [PHASES];
      logic [BASE_W-1:0] size_list [PHASES];
      base_list = '{32'd0, 32'd4294966271, 32'hFFFF_FF00, 32'd1000, 32'd0, 32'd7,
                    32'd123, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0};
      size_list = '{32'd1024, 32'd1024, 32'd512, 32'd0, 32'd2047, 32'd1,
                    32'd64, 32'd65, 32'd0, 32'd0, 32'd0};
      for (int p = 8; p < PHASES; p++) begin
         base_list[p] = $urandom_range(0, 32'd4294966271);
         size_list[p] = (p == 10) ? $urandom_range(1025, 2047) : $urandom_range(1, 1024);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: walk before any start, extremes of the index, every operation
      send_request(OP_NEXT, 32'd0);
      send_request(OP_MIN, 32'd0);
      send_request(OP_MAX, 32'hFFFF_FFFF);
      send_request(OP_ADD, 32'd0);
      send_request(OP_ADD, 32'd1023);
      send_request(OP_ADD, 32'd1024);
      send_request(OP_ADD, 32'hFFFF_FFFF);
      send_request(OP_ADD, 32'd64);
      send_request(OP_ADD, 32'd640);
      send_request(OP_TEST, 32'd1023);
      send_request(OP_TEST, 32'd1);
      send_request(OP_TEST, 32'hFFFF_FFFF);
      send_request(OP_MIN, 32'd0);
      send_request(OP_MAX, 32'd0);
      send_request(OP_START, 32'd0);
      repeat (5) send_request(OP_NEXT, 32'd0);
      send_request(OP_REMOVE, 32'd1023);
      send_request(OP_REMOVE, 32'd5000);
      send_request(OP_MAX, 32'd0);
      // clear keeps the walk cursor
      send_request(OP_CLEAR, 32'd0);
      send_request(OP_NEXT, 32'd0);
      await_results();

      // random phases across register settings, some with no idling at all
      for (int p = 0; p < PHASES; p++) begin
         quiet = (p % 3 == 2);
         apply_settings(base_list[p], size_list[p]);
         while (items_sent < 25 + (p + 1) * PER_PHASE) random_item();
         await_results();
      end

      repeat (24) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("FAIL");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/bsff_pkg.sv
sv/bsff_ctrl.sv
sv/bsff_dpath.sv
sv/bitmap_set_find_first.sv
sv/bsff_checker.sv
bench/bsff_checker.sv
bench/tb.sv
